/* rtl/arp_responder_and_cache_defines.svh */
// Assertion macros shared by the ARP engine RTL.
// Used by the files that check properties; depends on a clk and rst in scope.
`ifndef ARP_RESPONDER_AND_CACHE_DEFINES_SVH
`define ARP_RESPONDER_AND_CACHE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/arpc_pkg.sv */
// Shared types, constants and the control store of the ARP engine.
// Used by arpc_ucode_seq, arpc_cache and arp_responder_and_cache.
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 64;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int OPER_W = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [OPER_W-1:0] OPER_REQUEST = 16'h0001;

  localparam logic [REG_IDX_W-1:0] REG_OWN_MAC     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OWN_IP      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SUBNET_MASK = 2'd2;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_HIT     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STEP_WAIT     = 3'd0,
    STEP_SCAN     = 3'd1,
    STEP_DISPATCH = 3'd2,
    STEP_HEADER   = 3'd3,
    STEP_QUERY    = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_SCAN_MORE,
    COND_QUERY
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  load;
    logic  scan;
    logic  write_entry;
    logic  emit_reply;
    logic  emit_query;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic scan_more;
    logic is_query;
  } status_t;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w = '{cond: COND_ALWAYS, target: STEP_WAIT, load: 1'b0, scan: 1'b0,
          write_entry: 1'b0, emit_reply: 1'b0, emit_query: 1'b0};
    case (step)
      STEP_WAIT: begin
        w.cond   = COND_NO_START;
        w.target = STEP_WAIT;
        w.load   = 1'b1;
      end
      STEP_SCAN: begin
        w.cond   = COND_SCAN_MORE;
        w.target = STEP_SCAN;
        w.scan   = 1'b1;
      end
      STEP_DISPATCH: begin
        w.cond   = COND_QUERY;
        w.target = STEP_QUERY;
      end
      STEP_HEADER: begin
        w.cond        = COND_ALWAYS;
        w.target      = STEP_WAIT;
        w.write_entry = 1'b1;
        w.emit_reply  = 1'b1;
      end
      STEP_QUERY: begin
        w.cond       = COND_ALWAYS;
        w.target     = STEP_WAIT;
        w.emit_query = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/arp_responder_and_cache.sv */
// Top level of the ARP engine: config registers, item latch, result stage.
// Depends on arpc_pkg, arpc_ucode_seq, arpc_cache and the macros header.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------
//   item in   | start, busy            | command operation sender_mac
//             |                        | sender_ip target_ip query_ip
//   result    | result_strobe          | result_kind peer_mac peer_ip
//   config    | cfg_valid, cfg_ready   | cfg_index cfg_data
//
// An item keeps busy high through the scan, dispatch and header or query steps; the
// scan covers the valid cache entries (at most CACHE_ENTRIES) and ends on a hit.
// The scan reads one entry a cycle; a result, if any, shows for one cycle in the
// first cycle with busy low. The receiver cannot stall the engine.
// Reset empties the cache at once through the fill count; no clearing pass.
// Config writes are taken every cycle; write them only while busy is low.
`include "arp_responder_and_cache_defines.svh"

module arp_responder_and_cache #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [arpc_pkg::OPER_W-1:0]       operation,
  input  logic [arpc_pkg::MAC_W-1:0]        sender_mac,
  input  logic [arpc_pkg::IP_W-1:0]         sender_ip,
  input  logic [arpc_pkg::IP_W-1:0]         target_ip,
  input  logic [arpc_pkg::IP_W-1:0]         query_ip,
  output logic                              result_strobe,
  output logic [1:0]                        result_kind,
  output logic [arpc_pkg::MAC_W-1:0]        peer_mac,
  output logic [arpc_pkg::IP_W-1:0]         peer_ip,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arpc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [arpc_pkg::MAC_W-1:0]        cfg_data
);

  logic [arpc_pkg::MAC_W-1:0]  own_mac;
  logic [arpc_pkg::IP_W-1:0]   own_ip;
  logic [arpc_pkg::IP_W-1:0]   subnet_mask;

  logic                        cmd;
  logic [arpc_pkg::OPER_W-1:0] oper;
  logic [arpc_pkg::MAC_W-1:0]  smac;
  logic [arpc_pkg::IP_W-1:0]   sip;
  logic [arpc_pkg::IP_W-1:0]   tip;
  logic [arpc_pkg::IP_W-1:0]   qip;

  arpc_pkg::ctrl_t             ctrl;
  arpc_pkg::status_t           status;
  logic                        scan_more;
  logic                        hit;
  logic [arpc_pkg::MAC_W-1:0]  hit_mac;
  logic [arpc_pkg::IP_W-1:0]   key_ip;

  logic                        reply_due;
  logic                        request_due;

  assign cfg_ready = 1'b1;
  assign key_ip    = (cmd == arpc_pkg::CMD_QUERY) ? qip : sip;

  assign status = '{start: start, scan_more: scan_more,
                    is_query: (cmd == arpc_pkg::CMD_QUERY)};

  arpc_ucode_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  arpc_cache #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .key_ip    (key_ip),
    .wr_mac    (smac),
    .scan_more (scan_more),
    .hit       (hit),
    .hit_mac   (hit_mac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac     <= '0;
      own_ip      <= '0;
      subnet_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arpc_pkg::REG_OWN_MAC:     own_mac     <= cfg_data;
        arpc_pkg::REG_OWN_IP:      own_ip      <= cfg_data[arpc_pkg::IP_W-1:0];
        arpc_pkg::REG_SUBNET_MASK: subnet_mask <= cfg_data[arpc_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the item while the sequencer works on it
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd  <= command;
      oper <= operation;
      smac <= sender_mac;
      sip  <= sender_ip;
      tip  <= target_ip;
      qip  <= query_ip;
    end
  end

  assign reply_due   = ctrl.emit_reply && (oper == arpc_pkg::OPER_REQUEST) && (tip == own_ip);
  assign request_due = ctrl.emit_query && !hit
                       && ((qip & subnet_mask) == (own_ip & subnet_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= reply_due || (ctrl.emit_query && hit) || request_due;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_due) begin
      result_kind <= arpc_pkg::KIND_REPLY;
      peer_mac    <= smac;
      peer_ip     <= sip;
    end else if (ctrl.emit_query && hit) begin
      result_kind <= arpc_pkg::KIND_HIT;
      peer_mac    <= hit_mac;
      peer_ip     <= qip;
    end else if (request_due) begin
      result_kind <= arpc_pkg::KIND_REQUEST;
      peer_mac    <= '0;
      peer_ip     <= qip;
    end
  end

  `ARPC_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted item did not start")
  `ARPC_ASSERT_NOW(a_result_after_work, result_strobe, $past(busy) && !busy,
                   "result outside the end of an item")
  `ARPC_ASSERT_NEXT(a_single_result, result_strobe, !result_strobe, "two results for one item")

endmodule

/* rtl/arpc_ucode_seq.sv */
// Step counter and conditional jump logic of the ARP engine sequencer.
// Depends on arpc_pkg for the control store and control word types.
module arpc_ucode_seq (
  input  logic             clk,
  input  logic             rst,
  input  arpc_pkg::status_t status,
  output arpc_pkg::ctrl_t   ctrl,
  output logic             busy
);

  arpc_pkg::step_t pc;
  arpc_pkg::step_t pc_next;
  logic            take;

  always_comb begin
    ctrl = arpc_pkg::ucode(pc);
  end

  always_comb begin
    case (ctrl.cond)
      arpc_pkg::COND_NEVER:     take = 1'b0;
      arpc_pkg::COND_ALWAYS:    take = 1'b1;
      arpc_pkg::COND_NO_START:  take = !status.start;
      arpc_pkg::COND_SCAN_MORE: take = status.scan_more;
      arpc_pkg::COND_QUERY:     take = status.is_query;
      default:                  take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = arpc_pkg::step_t'(pc + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= arpc_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != arpc_pkg::STEP_WAIT);

endmodule

/* rtl/arpc_cache.sv */
// Address cache: IP and MAC memories, fill count, insert pointer and scan.
// Depends on arpc_pkg and on the assertion macros header.
`include "arp_responder_and_cache_defines.svh"

module arpc_cache #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  arpc_pkg::ctrl_t            ctrl,
  input  logic [arpc_pkg::IP_W-1:0]  key_ip,
  input  logic [arpc_pkg::MAC_W-1:0] wr_mac,
  output logic                       scan_more,
  output logic                       hit,
  output logic [arpc_pkg::MAC_W-1:0] hit_mac
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(CACHE_ENTRIES);

  logic [arpc_pkg::IP_W-1:0]  mem_ip  [CACHE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] mem_mac [CACHE_ENTRIES];

  logic [CNT_W-1:0]           fill;
  logic [IDX_W-1:0]           insert_slot;
  logic [CNT_W-1:0]           scan_idx;
  logic [IDX_W-1:0]           rd_idx;
  logic                       rd_pend;
  logic [arpc_pkg::IP_W-1:0]  rd_ip;
  logic [arpc_pkg::MAC_W-1:0] rd_mac;
  logic [IDX_W-1:0]           hit_idx;

  logic             match_now;
  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  assign match_now = rd_pend && (rd_ip == key_ip);
  assign issue     = ctrl.scan && (scan_idx < fill) && !match_now;
  assign rd_addr   = scan_idx[IDX_W-1:0];
  assign wr_addr   = hit ? hit_idx : insert_slot;
  assign scan_more = !match_now && ((scan_idx < fill) || rd_pend);

  always_ff @(posedge clk) begin
    if (ctrl.write_entry) begin
      mem_ip[wr_addr]  <= key_ip;
      mem_mac[wr_addr] <= wr_mac;
    end
    if (issue) begin
      rd_ip  <= mem_ip[rd_addr];
      rd_mac <= mem_mac[rd_addr];
      rd_idx <= rd_addr;
    end
    if (ctrl.scan && match_now) begin
      hit_idx <= rd_idx;
      hit_mac <= rd_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      insert_slot <= '0;
      scan_idx    <= '0;
      rd_pend     <= 1'b0;
      hit         <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (ctrl.load) begin
        scan_idx <= '0;
        hit      <= 1'b0;
      end
      if (issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (ctrl.scan && match_now) begin
        hit <= 1'b1;
      end
      if (ctrl.write_entry && !hit) begin
        insert_slot <= (insert_slot == LAST_SLOT) ? '0 : insert_slot + IDX_W'(1);
        if (fill != FULL) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  `ARPC_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FULL, "fill count above cache size")
  `ARPC_ASSERT_NOW(a_insert_tracks_fill, fill != FULL,
                   insert_slot == fill[IDX_W-1:0], "insert slot out of step with fill")
  `ARPC_ASSERT_NOW(a_hit_is_valid, hit, CNT_W'(hit_idx) < fill, "hit on an empty slot")

endmodule
